// ===== design/positional_list_engine_defines.svh =====
// Assertion macros shared by the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ple_pkg.sv =====
package ple_pkg;

    // Operation selector codes
    localparam logic [2:0] FN_INS_FRONT = 3'd0;
    localparam logic [2:0] FN_INS_END   = 3'd1;
    localparam logic [2:0] FN_INS_AT    = 3'd2;
    localparam logic [2:0] FN_DEL_FRONT = 3'd3;
    localparam logic [2:0] FN_DEL_END   = 3'd4;
    localparam logic [2:0] FN_DEL_AT    = 3'd5;
    localparam logic [2:0] FN_READ      = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Fixed field widths
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 7;
    localparam int HIN_W    = 32;
    localparam int RVAL_W   = 32;
    localparam int STAT_W   = 2;
    localparam int CNTO_W   = 7;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // Broadcast command to every cell of the chain
    typedef struct packed {
        logic ins;       // open a slot at target, shift higher cells up
        logic del;       // close the slot at target, shift higher cells down
        logic rd_load;   // copy stored values into the read chain
        logic rd_shift;  // move the read chain one cell toward cell 0
    } cell_op_t;

endpackage

// ===== design/ple_cell.sv =====
module ple_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7,
    parameter int HW    = 32
) (
    input  logic             aclk,
    input  ple_pkg::cell_op_t op,
    input  logic [CNT_W-1:0] target,
    input  logic [HW-1:0]    handle,
    input  logic [HW-1:0]    lower_val,   // value of cell IDX-1
    input  logic [HW-1:0]    upper_val,   // value of cell IDX+1
    input  logic [HW-1:0]    upper_rd,    // read chain of cell IDX+1
    output logic [HW-1:0]    val,
    output logic [HW-1:0]    rd
);
    import ple_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [HW-1:0] val_reg, val_next;
    logic [HW-1:0] rd_reg, rd_next;

    // Stored element: take new handle, or neighbor on a shift
    always_comb begin
        val_next = val_reg;
        if (op.ins) begin
            if (MY_IDX == target) begin
                val_next = handle;
            end else if (MY_IDX > target) begin
                val_next = lower_val;
            end
        end else if (op.del && (MY_IDX >= target)) begin
            val_next = upper_val;
        end
    end

    // Read chain: snapshot, then drain toward cell 0
    always_comb begin
        rd_next = rd_reg;
        if (op.rd_load) begin
            rd_next = val_reg;
        end else if (op.rd_shift) begin
            rd_next = upper_rd;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        rd_reg  <= rd_next;
    end

    assign val = val_reg;
    assign rd  = rd_reg;

endmodule

// ===== design/positional_list_engine.sv =====
// Positional list engine: an ordered list of up to CAPACITY handles held in
// a chain of cells, one element per cell, packed from position 0.
// Input channel s_axis_*: one transaction carries func, position and handle
// (insert front/end/at, delete front/end/at, read at position).
// Result channel m_axis_*: exactly one transaction per input with the value
// read (zero unless a successful read), a status and the count afterwards.
// Inserts, deletes, refused operations and unknown selectors give their
// result in the cycle after acceptance; a new transaction may be taken
// every cycle while the result register drains. A successful read copies
// the list into the cells' read chain and shifts it toward cell 0, one cell
// per cycle, and blocks the input until its result is registered.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; cell contents are not cleared. When the receiver holds
// m_axis_tready low the result stays in its register and s_axis_tready
// falls until it is taken.
`include "positional_list_engine_defines.svh"

module positional_list_engine #(
    parameter int CAPACITY     = 64,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] func, [9:3] position, [41:10] handle, [47:42] zero
    input  logic [ple_pkg::S_DATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] read_value, [33:32] status, [40:34] count, [47:41] zero
    output logic [ple_pkg::M_DATA_W-1:0]  m_axis_tdata
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int EXT_W = HANDLE_WIDTH + RVAL_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    // Input field unpacking
    logic [FUNC_W-1:0] in_func;
    logic [POS_W-1:0]  in_pos;
    logic [HIN_W-1:0]  in_handle;
    assign in_func   = s_axis_tdata[FUNC_W-1:0];
    assign in_pos    = s_axis_tdata[FUNC_W+POS_W-1:FUNC_W];
    assign in_handle = s_axis_tdata[FUNC_W+POS_W+HIN_W-1:FUNC_W+POS_W];

    // Control registers
    logic              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [RVAL_W-1:0] m_value_reg, m_value_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [CNTO_W-1:0] m_count_reg, m_count_next;

    logic accept;
    assign s_axis_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Operation decode
    logic [CMP_W-1:0]  pos_c, count_c;
    logic [CNT_W-1:0]  dec_target;
    logic [STAT_W-1:0] dec_status;
    logic [CNT_W-1:0]  dec_count;
    logic              dec_ins, dec_del, dec_rd;
    logic              is_full, is_empty;

    assign pos_c    = CMP_W'(in_pos);
    assign count_c  = CMP_W'(count_reg);
    assign is_full  = (count_reg == CAP_CNT);
    assign is_empty = (count_reg == '0);

    always_comb begin
        dec_target = '0;
        dec_status = ST_OK;
        dec_count  = count_reg;
        dec_ins    = 1'b0;
        dec_del    = 1'b0;
        dec_rd     = 1'b0;
        case (in_func)
            FN_INS_FRONT, FN_INS_END, FN_INS_AT: begin
                if (is_full) begin
                    dec_status = ST_FULL;
                end else if ((in_func == FN_INS_AT) && (pos_c > count_c)) begin
                    dec_status = ST_RANGE;
                end else begin
                    dec_ins   = 1'b1;
                    dec_count = count_reg + 1'b1;
                    if (in_func == FN_INS_END) begin
                        dec_target = count_reg;
                    end else if (in_func == FN_INS_AT) begin
                        dec_target = CNT_W'(pos_c);
                    end
                end
            end
            FN_DEL_FRONT, FN_DEL_END, FN_DEL_AT: begin
                if (is_empty) begin
                    dec_status = ST_EMPTY;
                end else if ((in_func == FN_DEL_AT) && (pos_c >= count_c)) begin
                    dec_status = ST_RANGE;
                end else begin
                    dec_del   = 1'b1;
                    dec_count = count_reg - 1'b1;
                    if (in_func == FN_DEL_END) begin
                        dec_target = count_reg - 1'b1;
                    end else if (in_func == FN_DEL_AT) begin
                        dec_target = CNT_W'(pos_c);
                    end
                end
            end
            FN_READ: begin
                if (pos_c >= count_c) begin
                    dec_status = ST_RANGE;
                end else begin
                    dec_rd = 1'b1;
                end
            end
            default: begin
                dec_status = ST_OK;
            end
        endcase
    end

    // Command broadcast to the cells
    cell_op_t         cell_op;
    logic [HANDLE_WIDTH-1:0] ins_handle;
    assign cell_op.ins      = accept && dec_ins;
    assign cell_op.del      = accept && dec_del;
    assign cell_op.rd_load  = accept && dec_rd;
    assign cell_op.rd_shift = (state_reg == S_READ) && (rd_cnt_reg != '0);
    assign ins_handle       = HANDLE_WIDTH'(in_handle);

    // Cell chain
    logic [HANDLE_WIDTH-1:0] cell_val [CAPACITY];
    logic [HANDLE_WIDTH-1:0] cell_rd  [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [HANDLE_WIDTH-1:0] lower_w, upper_w, upper_rd_w;
        if (i == 0) begin : g_first
            assign lower_w = '0;
        end else begin : g_mid_lo
            assign lower_w = cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign upper_w    = '0;
            assign upper_rd_w = '0;
        end else begin : g_mid_hi
            assign upper_w    = cell_val[i+1];
            assign upper_rd_w = cell_rd[i+1];
        end
        ple_cell #(
            .IDX   (i),
            .CNT_W (CNT_W),
            .HW    (HANDLE_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .op        (cell_op),
            .target    (dec_target),
            .handle    (ins_handle),
            .lower_val (lower_w),
            .upper_val (upper_w),
            .upper_rd  (upper_rd_w),
            .val       (cell_val[i]),
            .rd        (cell_rd[i])
        );
    end

    logic [EXT_W-1:0] rd_ext;
    assign rd_ext = EXT_W'(cell_rd[0]);

    // Sequencer and result register
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_cnt_next   = rd_cnt_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    count_next = dec_count;
                    if (dec_rd) begin
                        state_next  = S_READ;
                        rd_cnt_next = in_pos;
                    end else begin
                        m_valid_next  = 1'b1;
                        m_value_next  = '0;
                        m_status_next = dec_status;
                        m_count_next  = CNTO_W'(dec_count);
                    end
                end
            end
            S_READ: begin
                if (rd_cnt_reg == '0) begin
                    state_next    = S_IDLE;
                    m_valid_next  = 1'b1;
                    m_value_next  = rd_ext[RVAL_W-1:0];
                    m_status_next = ST_OK;
                    m_count_next  = CNTO_W'(count_reg);
                end else begin
                    rd_cnt_next = rd_cnt_reg - 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_cnt_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_cnt_reg  <= rd_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_DATA_W - RVAL_W - STAT_W - CNTO_W)'(0),
                            m_count_reg, m_status_reg, m_value_reg};

    // Checks
    `PLE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CAP_CNT, "element count above capacity")
    `PLE_ASSERT_NOW(a_read_blocks, state_reg == S_READ, !s_axis_tready, "input taken during read")
    `PLE_ASSERT_NEXT(a_quick_result, accept && !dec_rd, m_axis_tvalid, "result missing after update")

endmodule
